// ----- sv/chm_pkg.sv -----
// Shared types and codes of the chained hash map.
package chm_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_RESET = 50;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_RH_CLR,
        S_RH_BR,
        S_RH_BW,
        S_RH_NR,
        S_RH_NW,
        S_RH_DIV,
        S_RH_HR,
        S_RH_HW,
        S_HASH,
        S_HDIV,
        S_HEADR,
        S_HEADW,
        S_WALK,
        S_WALKW,
        S_RM1,
        S_RM2,
        S_ALLOCW,
        S_DONE
    } t_state;

endpackage

// ----- sv/chm_mod.sv -----
// Bit-serial restoring remainder unit: dividend modulo divisor.
module chm_mod #(
    parameter int KW = 32,
    parameter int NW = 11,
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [KW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_done,
    output logic [AW-1:0] o_rem
);
    localparam int CNTW = $clog2(KW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [KW-1:0]   r_dvd, n_dvd;
    logic [NW:0]     r_rem, n_rem;
    logic [NW-1:0]   r_div, n_div;
    logic [NW:0]     w_t;

    assign w_t = {r_rem[NW-1:0], r_dvd[KW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(KW);
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = (w_t >= {1'b0, r_div}) ? w_t - {1'b0, r_div} : w_t;
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];
endmodule

// ----- sv/chained_hash_map_core.sv -----
// Chained hash map core: top level with sequencer and node memories.
// One operation at a time. Each key is reduced modulo the bucket count by a
// bit-serial remainder unit, and a find, insert or remove then walks the chain
// of that bucket node by node. An insert that finds the entry count equal to
// the bucket count first rehashes the whole table into the other bank of bucket
// heads, unless the count is already at MAX_BUCKETS: it clears the new heads,
// then moves each stored node bucket by bucket. After reset and after each clear
// operation a clearing pass over all MAX_BUCKETS heads and links runs before the
// next item is taken; a clear answers at its end.
module chained_hash_map_core #(
    parameter int MAX_BUCKETS = 1024,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_opcode,
    input  logic [KEY_WIDTH-1:0]       i_key,
    input  logic [VALUE_WIDTH-1:0]     i_insert_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [VALUE_WIDTH-1:0]     o_found_value,
    output logic [$clog2(MAX_BUCKETS):0] o_entry_count,
    output logic                       o_is_empty,
    input  logic                       i_cfg_we,
    input  logic [chm_pkg::CFG_W-1:0]  i_cfg_wdata
);
    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int NW = AW + 1;
    localparam int KW = KEY_WIDTH;
    localparam int VW = VALUE_WIDTH;
    localparam logic [NW-1:0] NIL = NW'(MAX_BUCKETS);

    logic [NW-1:0] mem_heads [2**NW];
    logic [KW-1:0] mem_keys  [2**AW];
    logic [VW-1:0] mem_vals  [2**AW];
    logic [NW-1:0] mem_links [2**AW];

    chm_pkg::t_state r_state, n_state;

    logic [1:0]              r_op, n_op;
    logic [KW-1:0]           r_key, n_key;
    logic [VW-1:0]           r_val, n_val;
    logic [chm_pkg::CFG_W-1:0] r_cfg;
    logic                    r_bank, n_bank;
    logic [NW-1:0]           r_buckets, n_buckets;
    logic [NW-1:0]           r_count, n_count;
    logic [NW-1:0]           r_free, n_free;
    logic [NW-1:0]           r_i, n_i;
    logic [AW-1:0]           r_b, n_b;
    logic [AW-1:0]           r_idx, n_idx;
    logic [NW-1:0]           r_n, n_n;
    logic [NW-1:0]           r_prev, n_prev;
    logic [NW-1:0]           r_next, n_next;
    logic [NW-1:0]           r_head, n_head;
    logic [NW-1:0]           r_grown, n_grown;
    logic [1:0]              r_status, n_status;
    logic [VW-1:0]           r_found, n_found;
    logic                    r_clr_rsp, n_clr_rsp;
    logic                    r_out_valid, n_out_valid;
    logic [1:0]              r_o_status, n_o_status;
    logic [VW-1:0]           r_o_found, n_o_found;
    logic [NW-1:0]           r_o_count, n_o_count;

    logic [NW-1:0] r_head_q;
    logic [KW-1:0] r_key_q;
    logic [VW-1:0] r_val_q;
    logic [NW-1:0] r_link_q;

    logic          w_hd_we;
    logic [NW-1:0] w_hd_wa, w_hd_ra, w_hd_wd;
    logic          w_lk_we;
    logic [AW-1:0] w_lk_wa;
    logic [NW-1:0] w_lk_wd;
    logic          w_key_we, w_val_we;
    logic [AW-1:0] w_kv_wa, w_node_ra;
    logic [VW-1:0] w_val_wd;

    logic          w_start, w_done;
    logic [KW-1:0] w_dividend;
    logic [NW-1:0] w_divisor;
    logic [AW-1:0] w_rem;

    logic          w_accept, w_out_free, w_last_b;
    logic [NW:0]   w_dbl;
    logic [NW-1:0] w_grow_to, w_clamp;

    assign w_accept   = i_in_valid && (r_state == chm_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_dbl      = {r_buckets, 1'b0};
    assign w_grow_to  = (w_dbl > (NW + 1)'(MAX_BUCKETS)) ? NIL : w_dbl[NW-1:0];
    assign w_last_b   = (NW'(r_b) + 1'b1) == r_buckets;

    always_comb begin
        if (r_cfg == '0) begin
            w_clamp = NW'(1);
        end else if (32'(r_cfg) > 32'(MAX_BUCKETS)) begin
            w_clamp = NIL;
        end else begin
            w_clamp = NW'(r_cfg);
        end
    end

    assign w_start    = (r_state == chm_pkg::S_HASH) || (r_state == chm_pkg::S_RH_NW);
    assign w_dividend = (r_state == chm_pkg::S_RH_NW) ? r_key_q : r_key;
    assign w_divisor  = (r_state == chm_pkg::S_RH_NW) ? r_grown : r_buckets;

    chm_mod #(
        .KW(KW),
        .NW(NW),
        .AW(AW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chm_pkg::S_SWEEP: begin
                if (r_i == NW'(MAX_BUCKETS - 1)) begin
                    n_state = r_clr_rsp ? chm_pkg::S_DONE : chm_pkg::S_IDLE;
                end
            end
            chm_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == chm_pkg::OP_CLEAR) begin
                        n_state = chm_pkg::S_SWEEP;
                    end else if (i_opcode == chm_pkg::OP_INSERT && r_count == r_buckets
                                 && w_grow_to != r_buckets) begin
                        n_state = chm_pkg::S_RH_CLR;
                    end else begin
                        n_state = chm_pkg::S_HASH;
                    end
                end
            end
            chm_pkg::S_RH_CLR: begin
                if (r_i == r_grown - 1'b1) n_state = chm_pkg::S_RH_BR;
            end
            chm_pkg::S_RH_BR: n_state = chm_pkg::S_RH_BW;
            chm_pkg::S_RH_BW: begin
                if (r_head_q < NIL) begin
                    n_state = chm_pkg::S_RH_NR;
                end else begin
                    n_state = w_last_b ? chm_pkg::S_HASH : chm_pkg::S_RH_BR;
                end
            end
            chm_pkg::S_RH_NR: n_state = chm_pkg::S_RH_NW;
            chm_pkg::S_RH_NW: n_state = chm_pkg::S_RH_DIV;
            chm_pkg::S_RH_DIV: begin
                if (w_done) n_state = chm_pkg::S_RH_HR;
            end
            chm_pkg::S_RH_HR: n_state = chm_pkg::S_RH_HW;
            chm_pkg::S_RH_HW: begin
                if (r_next < NIL) begin
                    n_state = chm_pkg::S_RH_NR;
                end else begin
                    n_state = w_last_b ? chm_pkg::S_HASH : chm_pkg::S_RH_BR;
                end
            end
            chm_pkg::S_HASH: n_state = chm_pkg::S_HDIV;
            chm_pkg::S_HDIV: begin
                if (w_done) n_state = chm_pkg::S_HEADR;
            end
            chm_pkg::S_HEADR: n_state = chm_pkg::S_HEADW;
            chm_pkg::S_HEADW: n_state = chm_pkg::S_WALK;
            chm_pkg::S_WALK: begin
                if (r_n < NIL) begin
                    n_state = chm_pkg::S_WALKW;
                end else if (r_op == chm_pkg::OP_INSERT && r_free < NIL) begin
                    n_state = chm_pkg::S_ALLOCW;
                end else begin
                    n_state = chm_pkg::S_DONE;
                end
            end
            chm_pkg::S_WALKW: begin
                if (r_key_q == r_key) begin
                    n_state = (r_op == chm_pkg::OP_REMOVE) ? chm_pkg::S_RM1 : chm_pkg::S_DONE;
                end else begin
                    n_state = chm_pkg::S_WALK;
                end
            end
            chm_pkg::S_RM1:    n_state = chm_pkg::S_RM2;
            chm_pkg::S_RM2:    n_state = chm_pkg::S_DONE;
            chm_pkg::S_ALLOCW: n_state = chm_pkg::S_DONE;
            chm_pkg::S_DONE: begin
                if (w_out_free) n_state = chm_pkg::S_IDLE;
            end
            default: n_state = chm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_key     = r_key;
        n_val     = r_val;
        n_bank    = r_bank;
        n_buckets = r_buckets;
        n_count   = r_count;
        n_free    = r_free;
        n_i       = r_i;
        n_b       = r_b;
        n_idx     = r_idx;
        n_n       = r_n;
        n_prev    = r_prev;
        n_next    = r_next;
        n_head    = r_head;
        n_grown   = r_grown;
        n_status  = r_status;
        n_found   = r_found;
        n_clr_rsp = r_clr_rsp;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_count  = r_o_count;
        n_out_valid = r_out_valid && i_out_stall;

        w_hd_we  = 1'b0;
        w_hd_wa  = {r_bank, r_b};
        w_hd_wd  = NIL;
        w_hd_ra  = {r_bank, r_b};
        w_lk_we  = 1'b0;
        w_lk_wa  = r_n[AW-1:0];
        w_lk_wd  = r_free;
        w_key_we = 1'b0;
        w_val_we = 1'b0;
        w_kv_wa  = r_n[AW-1:0];
        w_val_wd = r_val;
        w_node_ra = r_n[AW-1:0];

        unique case (r_state)
            chm_pkg::S_SWEEP: begin
                w_hd_we = 1'b1;
                w_hd_wa = {r_bank, r_i[AW-1:0]};
                w_lk_we = 1'b1;
                w_lk_wa = r_i[AW-1:0];
                w_lk_wd = r_i + 1'b1;
                n_i     = r_i + 1'b1;
            end
            chm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_opcode;
                    n_key    = i_key;
                    n_val    = i_insert_value;
                    n_status = chm_pkg::ST_OK;
                    n_found  = '0;
                    n_i      = '0;
                    n_b      = '0;
                    n_grown  = w_grow_to;
                    if (i_opcode == chm_pkg::OP_CLEAR) begin
                        n_buckets = w_clamp;
                        n_count   = '0;
                        n_free    = '0;
                        n_clr_rsp = 1'b1;
                    end
                end
            end
            chm_pkg::S_RH_CLR: begin
                w_hd_we = 1'b1;
                w_hd_wa = {~r_bank, r_i[AW-1:0]};
                n_i     = r_i + 1'b1;
            end
            chm_pkg::S_RH_BR: begin
                w_hd_ra = {r_bank, r_b};
            end
            chm_pkg::S_RH_BW: begin
                n_n = r_head_q;
                if (r_head_q >= NIL) begin
                    if (w_last_b) begin
                        n_bank    = ~r_bank;
                        n_buckets = r_grown;
                    end else begin
                        n_b = r_b + 1'b1;
                    end
                end
            end
            chm_pkg::S_RH_NR: begin
                w_node_ra = r_n[AW-1:0];
            end
            chm_pkg::S_RH_NW: begin
                n_next = r_link_q;
            end
            chm_pkg::S_RH_DIV: begin
                if (w_done) n_idx = w_rem;
            end
            chm_pkg::S_RH_HR: begin
                w_hd_ra = {~r_bank, r_idx};
            end
            chm_pkg::S_RH_HW: begin
                w_lk_we = 1'b1;
                w_lk_wa = r_n[AW-1:0];
                w_lk_wd = r_head_q;
                w_hd_we = 1'b1;
                w_hd_wa = {~r_bank, r_idx};
                w_hd_wd = r_n;
                n_n     = r_next;
                if (r_next >= NIL) begin
                    if (w_last_b) begin
                        n_bank    = ~r_bank;
                        n_buckets = r_grown;
                    end else begin
                        n_b = r_b + 1'b1;
                    end
                end
            end
            chm_pkg::S_HASH: begin
            end
            chm_pkg::S_HDIV: begin
                if (w_done) n_b = w_rem;
            end
            chm_pkg::S_HEADR: begin
                w_hd_ra = {r_bank, r_b};
            end
            chm_pkg::S_HEADW: begin
                n_n    = r_head_q;
                n_head = r_head_q;
                n_prev = NIL;
            end
            chm_pkg::S_WALK: begin
                w_node_ra = (r_n < NIL) ? r_n[AW-1:0] : r_free[AW-1:0];
                if (r_n >= NIL) begin
                    if (r_op != chm_pkg::OP_INSERT) begin
                        n_status = chm_pkg::ST_ABSENT;
                    end else if (r_free >= NIL) begin
                        n_status = chm_pkg::ST_FULL;
                    end
                end
            end
            chm_pkg::S_WALKW: begin
                n_next = r_link_q;
                if (r_key_q == r_key) begin
                    if (r_op == chm_pkg::OP_FIND) begin
                        n_found = r_val_q;
                    end else if (r_op == chm_pkg::OP_INSERT) begin
                        w_val_we = 1'b1;
                        w_kv_wa  = r_n[AW-1:0];
                        w_val_wd = r_val_q + 1'b1;
                        n_found  = r_val_q + 1'b1;
                        n_status = chm_pkg::ST_ABSENT;
                    end
                end else begin
                    n_prev = r_n;
                    n_n    = r_link_q;
                end
            end
            chm_pkg::S_RM1: begin
                if (r_prev >= NIL) begin
                    w_hd_we = 1'b1;
                    w_hd_wa = {r_bank, r_b};
                    w_hd_wd = r_next;
                end else begin
                    w_lk_we = 1'b1;
                    w_lk_wa = r_prev[AW-1:0];
                    w_lk_wd = r_next;
                end
            end
            chm_pkg::S_RM2: begin
                w_lk_we = 1'b1;
                w_lk_wa = r_n[AW-1:0];
                w_lk_wd = r_free;
                n_free  = r_n;
                n_count = r_count - 1'b1;
            end
            chm_pkg::S_ALLOCW: begin
                w_key_we = 1'b1;
                w_val_we = 1'b1;
                w_kv_wa  = r_free[AW-1:0];
                w_val_wd = r_val;
                w_lk_we  = 1'b1;
                w_lk_wa  = r_free[AW-1:0];
                w_lk_wd  = r_head;
                w_hd_we  = 1'b1;
                w_hd_wa  = {r_bank, r_b};
                w_hd_wd  = r_free;
                n_free   = r_link_q;
                n_count  = r_count + 1'b1;
            end
            chm_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_found   = r_found;
                    n_o_count   = r_count;
                    n_clr_rsp   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hd_we) mem_heads[w_hd_wa] <= w_hd_wd;
        r_head_q <= mem_heads[w_hd_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_lk_we) mem_links[w_lk_wa] <= w_lk_wd;
        r_link_q <= mem_links[w_node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) mem_keys[w_kv_wa] <= r_key;
        r_key_q <= mem_keys[w_node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) mem_vals[w_kv_wa] <= w_val_wd;
        r_val_q <= mem_vals[w_node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chm_pkg::S_SWEEP;
            r_cfg       <= chm_pkg::CFG_W'(chm_pkg::CFG_RESET);
            r_bank      <= 1'b0;
            r_buckets   <= (chm_pkg::CFG_RESET > MAX_BUCKETS) ? NIL : NW'(chm_pkg::CFG_RESET);
            r_count     <= '0;
            r_free      <= '0;
            r_i         <= '0;
            r_clr_rsp   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            r_bank      <= n_bank;
            r_buckets   <= n_buckets;
            r_count     <= n_count;
            r_free      <= n_free;
            r_i         <= n_i;
            r_clr_rsp   <= n_clr_rsp;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_key      <= n_key;
        r_val      <= n_val;
        r_b        <= n_b;
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_prev     <= n_prev;
        r_next     <= n_next;
        r_head     <= n_head;
        r_grown    <= n_grown;
        r_status   <= n_status;
        r_found    <= n_found;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_count  <= n_o_count;
    end

    assign o_in_stall    = r_state != chm_pkg::S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_found_value = r_o_found;
    assign o_entry_count = r_o_count;
    assign o_is_empty    = r_o_count == '0;
endmodule

// ----- tb/chained_hash_map_checker.sv -----
// Checker for the chained hash map core: predicts each result and compares transfers.
`timescale 1ns / 1ps

module chained_hash_map_checker #(
    parameter int MAX_BUCKETS = 1024,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic [KEY_WIDTH-1:0]         i_key,
    input  logic [VALUE_WIDTH-1:0]       i_insert_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [1:0]                   i_status,
    input  logic [VALUE_WIDTH-1:0]       i_found_value,
    input  logic [$clog2(MAX_BUCKETS):0] i_entry_count,
    input  logic                         i_is_empty,
    input  logic                         i_cfg_we,
    input  logic [chm_pkg::CFG_W-1:0]    i_cfg_wdata,
    output int                           o_errors,
    output int                           o_pending
);

    localparam int NIL = MAX_BUCKETS;
    localparam int CW  = $clog2(MAX_BUCKETS) + 1;

    typedef struct packed {
        logic [1:0]             status;
        logic [VALUE_WIDTH-1:0] found;
        logic [CW-1:0]          count;
        logic                   empty;
    } t_map_result;

    t_map_result               answer_q[$];
    logic [chm_pkg::CFG_W-1:0] start_reg;
    int                        heads[MAX_BUCKETS];
    int                        links[MAX_BUCKETS];
    logic [KEY_WIDTH-1:0]      keys[MAX_BUCKETS];
    logic [VALUE_WIDTH-1:0]    vals[MAX_BUCKETS];
    int                        free_head;
    int                        stored;
    int                        nbuckets;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int start_buckets();
        if (start_reg == 0) return 1;
        if (int'(start_reg) > MAX_BUCKETS) return MAX_BUCKETS;
        return int'(start_reg);
    endfunction

    function automatic void empty_map();
        for (int i = 0; i < MAX_BUCKETS; i++) begin
            heads[i] = NIL;
            links[i] = i + 1;
        end
        links[MAX_BUCKETS-1] = NIL;
        free_head = 0;
        stored    = 0;
        nbuckets  = start_buckets();
    endfunction

    function automatic int bucket_of(logic [KEY_WIDTH-1:0] key, int n);
        logic [63:0] wide;
        wide = 64'(key);
        return int'(wide % 64'(n));
    endfunction

    function automatic int chain_find(logic [KEY_WIDTH-1:0] key, int b);
        int n;
        n = heads[b];
        while (n < NIL) begin
            if (keys[n] == key) return n;
            n = links[n];
        end
        return NIL;
    endfunction

    function automatic void grow_if_full();
        int grown;
        int n;
        int nxt;
        int idx;
        int scratch[MAX_BUCKETS];
        if (stored != nbuckets) return;
        grown = nbuckets * 2;
        if (grown > MAX_BUCKETS) grown = MAX_BUCKETS;
        if (grown == nbuckets) return;
        for (int b = 0; b < MAX_BUCKETS; b++) scratch[b] = NIL;
        for (int b = 0; b < nbuckets; b++) begin
            n = heads[b];
            while (n < NIL) begin
                nxt = links[n];
                idx = bucket_of(keys[n], grown);
                links[n] = scratch[idx];
                scratch[idx] = n;
                n = nxt;
            end
        end
        for (int b = 0; b < MAX_BUCKETS; b++) heads[b] = scratch[b];
        nbuckets = grown;
    endfunction

    function automatic t_map_result map_step(logic [1:0] op, logic [KEY_WIDTH-1:0] key,
                                             logic [VALUE_WIDTH-1:0] val);
        t_map_result r;
        int b;
        int n;
        int prev;
        r.status = chm_pkg::ST_OK;
        r.found  = '0;
        case (op)
            chm_pkg::OP_INSERT: begin
                grow_if_full();
                b = bucket_of(key, nbuckets);
                n = chain_find(key, b);
                if (n < NIL) begin
                    vals[n]  = vals[n] + 1'b1;
                    r.found  = vals[n];
                    r.status = chm_pkg::ST_ABSENT;
                end else if (free_head >= NIL) begin
                    r.status = chm_pkg::ST_FULL;
                end else begin
                    n         = free_head;
                    free_head = links[n];
                    keys[n]   = key;
                    vals[n]   = val;
                    links[n]  = heads[b];
                    heads[b]  = n;
                    stored++;
                end
            end
            chm_pkg::OP_REMOVE: begin
                b = bucket_of(key, nbuckets);
                n = heads[b];
                prev = NIL;
                r.status = chm_pkg::ST_ABSENT;
                while (n < NIL) begin
                    if (keys[n] == key) begin
                        if (prev >= NIL) heads[b] = links[n];
                        else links[prev] = links[n];
                        links[n] = free_head;
                        free_head = n;
                        stored--;
                        r.status = chm_pkg::ST_OK;
                        break;
                    end
                    prev = n;
                    n = links[n];
                end
            end
            chm_pkg::OP_FIND: begin
                n = chain_find(key, bucket_of(key, nbuckets));
                if (n < NIL) r.found = vals[n];
                else r.status = chm_pkg::ST_ABSENT;
            end
            default: empty_map();
        endcase
        r.count = CW'(stored);
        r.empty = (stored == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch in %s: got %0h, want %0h", what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_map_result want;
        if (!i_rst_n) begin
            start_reg = chm_pkg::CFG_W'(chm_pkg::CFG_RESET);
            empty_map();
            answer_q.delete();
        end else begin
            if (i_cfg_we) start_reg = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result status", 64'(i_status), '0);
                end else begin
                    want = answer_q.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", 64'(i_status), 64'(want.status));
                    if (i_found_value !== want.found)
                        report_mismatch("found_value", 64'(i_found_value), 64'(want.found));
                    if (i_entry_count !== want.count)
                        report_mismatch("entry_count", 64'(i_entry_count), 64'(want.count));
                    if (i_is_empty !== want.empty)
                        report_mismatch("is_empty", 64'(i_is_empty), 64'(want.empty));
                end
            end
            if (i_in_valid && !i_in_stall)
                answer_q.push_back(map_step(i_opcode, i_key, i_insert_value));
        end
        o_pending = answer_q.size();
    end

endmodule

// ----- tb/chained_hash_map_core_test.sv -----
// Testbench top for the chained hash map core: stimulus, idling and verdict.
`timescale 1ns / 1ps

module chained_hash_map_core_test;

    localparam int MAXB      = 1024;
    localparam int KW        = 32;
    localparam int VW        = 32;
    localparam int LIMIT     = 6000000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [1:0]                i_opcode;
    logic [KW-1:0]             i_key;
    logic [VW-1:0]             i_insert_value;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [1:0]                o_status;
    logic [VW-1:0]             o_found_value;
    logic [$clog2(MAXB):0]     o_entry_count;
    logic                      o_is_empty;
    logic                      i_cfg_we;
    logic [chm_pkg::CFG_W-1:0] i_cfg_wdata;

    int errors;
    int pending;
    int tx_idle;
    int rx_idle;
    int cycles;

    chained_hash_map_core #(.MAX_BUCKETS(MAXB), .KEY_WIDTH(KW), .VALUE_WIDTH(VW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_key(i_key), .i_insert_value(i_insert_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_found_value(o_found_value),
        .o_entry_count(o_entry_count), .o_is_empty(o_is_empty),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    chained_hash_map_checker #(.MAX_BUCKETS(MAXB), .KEY_WIDTH(KW), .VALUE_WIDTH(VW)) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_key(i_key), .i_insert_value(i_insert_value),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_status(o_status), .i_found_value(o_found_value),
        .i_entry_count(o_entry_count), .i_is_empty(o_is_empty),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < rx_idle);

    task automatic send_item(logic [1:0] op, logic [KW-1:0] key, logic [VW-1:0] val);
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_key          <= key;
        i_insert_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // drain all results, then let the block finish any trailing work
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic restart_with(logic [chm_pkg::CFG_W-1:0] start);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= start;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        send_item(chm_pkg::OP_CLEAR, $urandom, $urandom);
    endtask

    function automatic logic [KW-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65) return KW'($urandom_range(63));
        if (sel < 80) return KW'($urandom_range(7) * 50);
        if (sel < 88) return ~KW'($urandom_range(15));
        return KW'($urandom);
    endfunction

    function automatic logic [VW-1:0] pick_value();
        if ($urandom_range(9) == 0) return ~VW'($urandom_range(2));
        return VW'($urandom);
    endfunction

    task automatic random_items(int count);
        int sel;
        logic [1:0] op;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) op = chm_pkg::OP_INSERT;
            else if (sel < 70) op = chm_pkg::OP_REMOVE;
            else if (sel < 97) op = chm_pkg::OP_FIND;
            else op = chm_pkg::OP_CLEAR;
            send_item(op, pick_key(), pick_value());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = chm_pkg::OP_FIND;
        i_key          = '0;
        i_insert_value = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        tx_idle        = 18;
        rx_idle        = 69;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(chm_pkg::OP_FIND, 32'd0, 32'd0);
        send_item(chm_pkg::OP_REMOVE, 32'd0, 32'd0);
        send_item(chm_pkg::OP_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_item(chm_pkg::OP_INSERT, 32'd0, 32'd5);
        send_item(chm_pkg::OP_FIND, 32'd0, 32'd0);
        send_item(chm_pkg::OP_INSERT, 32'd50, 32'd0);
        send_item(chm_pkg::OP_INSERT, 32'd100, 32'h1234_5678);
        send_item(chm_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_item(chm_pkg::OP_REMOVE, 32'd50, 32'd0);
        send_item(chm_pkg::OP_FIND, 32'd100, 32'd0);
        send_item(chm_pkg::OP_FIND, 32'd50, 32'd0);
        send_item(chm_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'd0);
        send_item(chm_pkg::OP_REMOVE, 32'd7, 32'd0);
        // new start count only applies after a clear
        restart_with(11'd1);
        send_item(chm_pkg::OP_INSERT, 32'd3, 32'd1);
        send_item(chm_pkg::OP_INSERT, 32'd4, 32'd2);
        send_item(chm_pkg::OP_INSERT, 32'd5, 32'd3);
        send_item(chm_pkg::OP_FIND, 32'd3, 32'd0);
        send_item(chm_pkg::OP_CLEAR, 32'd0, 32'd0);
        send_item(chm_pkg::OP_FIND, 32'd3, 32'd0);
        random_items(40);

        tx_idle = 69;
        rx_idle = 18;
        restart_with(11'd0);
        random_items(40);

        restart_with(11'h7FF);
        for (int i = 0; i < MAXB; i++) begin
            send_item(chm_pkg::OP_INSERT, KW'(i * 3), VW'($urandom));
        end
        send_item(chm_pkg::OP_INSERT, 32'hDEAD_BEEF, 32'd9);
        send_item(chm_pkg::OP_INSERT, 32'd3, 32'd0);
        send_item(chm_pkg::OP_REMOVE, 32'd6, 32'd0);
        send_item(chm_pkg::OP_INSERT, 32'hDEAD_BEEF, 32'd9);
        send_item(chm_pkg::OP_FIND, 32'hDEAD_BEEF, 32'd0);

        tx_idle = 0;
        rx_idle = 0;
        restart_with(11'd1024);
        random_items(15);
        restart_with(11'd7);
        random_items(20);

        settle();
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
